>>> rtl/skht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skht_pkg: shared types and constants
// Transaction payload structs and status codes for the string-key hash table.
// ----------------------------------------------------------------------------
package skht_pkg;

	localparam int unsigned HASH_SEED  = 5381;
	localparam int unsigned HASH_SHIFT = 5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        inserted;
		logic [31:0] read_value;
		logic [9:0]  slot;
		logic [10:0] entry_total;
	} out_item_t;

endpackage

>>> rtl/string_key_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_key_hash_table_core: djb2-hashed key/value table, linear probing
// Streams key bytes, then probes slot memories one compare step per cycle.
// ----------------------------------------------------------------------------
// Steps: a non-last byte is taken and hashed. A last byte probes slots: per
//   slot, S_HDR and S_HDRW read the header, S_CMP compares key bytes when the
//   lengths match, S_NEXT moves on; S_DONE then registers the answer.
// Flow: one transaction at a time; an insert then copies the key bytes with
//   in_ready low, and the answer waits while an earlier result is unread.
// Reset: after arst_n releases, a clearing pass walks valid_mem, one slot a
//   cycle, while in_ready stays low.
module string_key_hash_table_core #(
	parameter int TABLE_SLOTS   = 1024,
	parameter int MAX_KEY_BYTES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  skht_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output skht_pkg::out_item_t  out_data
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int LW = $clog2(MAX_KEY_BYTES + 1);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int AW = IW + KW;
	localparam logic [IW:0] SEED_IDX = (IW + 1)'(skht_pkg::HASH_SEED % TABLE_SLOTS);
	localparam logic [IW:0] SLOTS_W  = (IW + 1)'(TABLE_SLOTS);
	localparam logic [LW-1:0] MAXK   = LW'(MAX_KEY_BYTES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HDR, S_HDRW, S_CMP, S_NEXT, S_DONE
	} state_t;

	state_t state_q;

	// slot memories
	logic               valid_mem [TABLE_SLOTS];
	logic [LW-1:0]      klen_mem  [TABLE_SLOTS];
	logic [31:0]        val_mem   [TABLE_SLOTS];
	logic [7:0]         kbyte_mem [TABLE_SLOTS * MAX_KEY_BYTES];
	logic [7:0]         kbuf_q    [MAX_KEY_BYTES];

	logic [IW:0]        hash_q;
	logic [LW-1:0]      klen_q;
	logic               ovf_q;
	logic               op_q;
	logic [31:0]        wval_q;
	logic [IW-1:0]      idx_q;
	logic [IW:0]        probes_q;
	logic [KW-1:0]      bi_q;
	logic [LW-1:0]      cnt_b_q;
	logic               rd_valid_q;
	logic [LW-1:0]      rd_klen_q;
	logic [31:0]        rd_val_q;
	logic [7:0]         rd_byte_q;
	logic               found_q;
	logic               empty_q;
	logic [CW-1:0]      occ_q;
	logic [IW-1:0]      clr_q;
	logic               out_valid_q;
	skht_pkg::out_item_t out_q;
	logic [LW-1:0]      cp_q;     // insert copy index
	logic               copying_q;

	// hash step: h*33 + b mod slots, done as (h<<5)+h+b then reduce
	logic [IW+14:0] hsum;
	logic [IW:0]    hnext;
	assign hsum = ({{14{1'b0}}, hash_q} << skht_pkg::HASH_SHIFT)
		+ {{14{1'b0}}, hash_q} + (IW + 15)'(in_data.key_byte);
	assign hnext = (IW + 1)'(hsum % TABLE_SLOTS);

	// answer only once the output register is free or being emptied
	logic answer_go;
	assign answer_go = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == S_IDLE) && !copying_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic [AW-1:0] baddr;
	assign baddr = {idx_q, bi_q};

	logic [IW-1:0] idx_inc;
	assign idx_inc = (idx_q == IW'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk) begin
		rd_valid_q <= valid_mem[idx_q];
		rd_klen_q  <= klen_mem[idx_q];
		rd_val_q   <= val_mem[idx_q];
		rd_byte_q  <= kbyte_mem[baddr];
		if (state_q == S_CLEAR)
			valid_mem[clr_q] <= 1'b0;
		else if (answer_go && op_q == skht_pkg::OP_SET && !ovf_q) begin
			if (found_q)
				val_mem[idx_q] <= wval_q;
			else if (empty_q) begin
				valid_mem[idx_q] <= 1'b1;
				klen_mem[idx_q]  <= klen_q;
				val_mem[idx_q]   <= wval_q;
			end
		end
		if (copying_q)
			kbyte_mem[{idx_q, cp_q[KW-1:0]}] <= kbuf_q[cp_q[KW-1:0]];
		if (in_valid && in_ready && klen_q < MAXK)
			kbuf_q[klen_q[KW-1:0]] <= in_data.key_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hash_q      <= SEED_IDX;
			klen_q      <= '0;
			ovf_q       <= 1'b0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			copying_q   <= 1'b0;
			cp_q        <= '0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			probes_q    <= '0;
			bi_q        <= '0;
			cnt_b_q     <= '0;
			idx_q       <= '0;
			op_q        <= 1'b0;
			wval_q      <= '0;
			out_q       <= '0;
		end else begin
			if (answer_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (copying_q) begin
				if (cp_q + 1'b1 >= klen_q) begin
					copying_q <= 1'b0;
					hash_q    <= SEED_IDX;
					klen_q    <= '0;
					ovf_q     <= 1'b0;
				end
				cp_q <= cp_q + 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(TABLE_SLOTS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						hash_q <= hnext;
						if (klen_q < MAXK)
							klen_q <= klen_q + 1'b1;
						else
							ovf_q <= 1'b1;
						if (in_data.key_last) begin
							op_q     <= in_data.operation;
							wval_q   <= in_data.value;
							idx_q    <= hnext[IW-1:0];
							probes_q <= '0;
							found_q  <= 1'b0;
							empty_q  <= 1'b0;
							state_q  <= (ovf_q || klen_q >= MAXK) ? S_DONE : S_HDR;
						end
					end
				end
				S_HDR: begin
					bi_q    <= '0;
					state_q <= S_HDRW;
				end
				S_HDRW: begin
					// header registered now; byte 0 is read here for S_CMP
					if (!rd_valid_q) begin
						empty_q <= 1'b1;
						state_q <= S_DONE;
					end else if (rd_klen_q != klen_q) begin
						state_q <= S_NEXT;
					end else begin
						cnt_b_q    <= '0;
						bi_q       <= (MAX_KEY_BYTES > 1) ? KW'(1) : '0;
						state_q    <= S_CMP;
					end
				end
				S_CMP: begin
					// shared byte comparator: one key byte per cycle
					if (rd_byte_q != kbuf_q[cnt_b_q[KW-1:0]]) begin
						state_q <= S_NEXT;
					end else if (cnt_b_q + 1'b1 >= klen_q) begin
						found_q  <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						cnt_b_q <= cnt_b_q + 1'b1;
						bi_q    <= bi_q + 1'b1;
					end
				end
				S_NEXT: begin
					if (probes_q + 1'b1 >= SLOTS_W)
						state_q <= S_DONE;
					else begin
						probes_q <= probes_q + 1'b1;
						idx_q    <= idx_inc;
						state_q  <= S_HDR;
					end
				end
				S_DONE: begin
					// hold here while the previous result is still unread
					if (answer_go) begin
						out_q.inserted    <= 1'b0;
						out_q.read_value  <= '0;
						out_q.slot        <= '0;
						out_q.entry_total <= 11'(occ_q);
						if (ovf_q)
							out_q.status <= skht_pkg::ST_TOO_LONG;
						else if (op_q == skht_pkg::OP_GET) begin
							if (found_q) begin
								out_q.status     <= skht_pkg::ST_OK;
								out_q.read_value <= rd_val_q;
								out_q.slot       <= 10'(idx_q);
							end else
								out_q.status <= skht_pkg::ST_NOT_FOUND;
						end else if (found_q) begin
							out_q.status <= skht_pkg::ST_OK;
							out_q.slot   <= 10'(idx_q);
						end else if (empty_q) begin
							out_q.status      <= skht_pkg::ST_OK;
							out_q.inserted    <= 1'b1;
							out_q.slot        <= 10'(idx_q);
							out_q.entry_total <= 11'(occ_q + 1'b1);
							occ_q             <= occ_q + 1'b1;
						end else
							out_q.status <= skht_pkg::ST_FULL;
						state_q <= S_IDLE;
						if (op_q == skht_pkg::OP_SET && !ovf_q && !found_q && empty_q
							&& klen_q != '0) begin
							copying_q <= 1'b1;
							cp_q      <= '0;
						end else begin
							hash_q <= SEED_IDX;
							klen_q <= '0;
							ovf_q  <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// occupancy never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= CW'(TABLE_SLOTS))
		else $error("occupancy overflow");
	// a result only comes out of the answer state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result without answer");
	// no new transaction while a key copy is running
	assert property (@(posedge clk) disable iff (!arst_n)
		copying_q |-> !in_ready)
		else $error("accept during copy");

endmodule
